@@ src/cubic_trajectory_interpolator_defines.svh @@
// assertion macros for the cubic trajectory interpolator
`ifndef CUBIC_TRAJECTORY_INTERPOLATOR_DEFINES_SVH
`define CUBIC_TRAJECTORY_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CTI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cti assertion failed");
`define CTI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cti assertion failed");
`else
`define CTI_ASSERT_IMP(lbl, ante, cons)
`define CTI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/ctip_pkg.sv @@
package ctip_pkg;
	localparam int POS_W  = 32;
	localparam int TICK_W = 16;
	localparam int COEF_W = 64;
	localparam int PROD_W = 48;

	localparam logic OP_GOAL = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [0:0] REG_DURATION = 1'b0;
	localparam logic [TICK_W-1:0] DUR_RESET = 16'd5000;

	function automatic logic [POS_W-1:0] sat32(input logic signed [COEF_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v > 64'sd2147483647) r = 32'h7fff_ffff;
		else if (v < -64'sd2147483648) r = 32'h8000_0000;
		else r = v[POS_W-1:0];
		return r;
	endfunction
endpackage

@@ src/ctip_div.sv @@
module ctip_div import ctip_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TICK_W-1:0] num,
	input  logic [TICK_W-1:0] den,
	output logic              done,
	output logic [POS_W-1:0]  quo
);
	logic [TICK_W-1:0] r_q;
	logic [POS_W-1:0]  q_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TICK_W:0]   r2;
	logic              ge;

	assign r2 = {r_q, 1'b0};
	assign ge = r2 >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= num;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? TICK_W'(r2 - {1'b0, den}) : r2[TICK_W-1:0];
			q_q <= {q_q[POS_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule

@@ src/ctip_imul.sv @@
module ctip_imul import ctip_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [POS_W-1:0]  a,
	input  logic [TICK_W-1:0]        b,
	output logic                     done,
	output logic signed [PROD_W-1:0] p
);
	logic signed [POS_W-1:0]  a_q;
	logic [TICK_W-1:0]        b_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [3:0]               cnt_q;
	logic                     busy_q;
	logic                     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// msb first shift-add
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< 1) + (b_q[TICK_W-1] ? PROD_W'(a_q) : '0);
			b_q   <= {b_q[TICK_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign p    = acc_q;
endmodule

@@ src/ctip_fmul.sv @@
module ctip_fmul import ctip_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [COEF_W-1:0] a,
	input  logic [POS_W-1:0]         b,
	output logic                     done,
	output logic signed [COEF_W-1:0] p
);
	logic [COEF_W-1:0] m_q;
	logic [POS_W-1:0]  b_q;
	logic [COEF_W-1:0] acc_q;
	logic              neg_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [COEF_W:0]   sum;

	assign sum = {1'b0, acc_q} + (b_q[0] ? {1'b0, m_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// lsb first, shift right each step: ends at floor(|a|*b / 2^32)
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[COEF_W-1];
			m_q   <= a[COEF_W-1] ? (~a + 64'd1) : a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= sum[COEF_W:1];
			b_q   <= {1'b0, b_q[POS_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = neg_q ? -$signed(acc_q) : $signed(acc_q);
endmodule

@@ src/cubic_trajectory_interpolator.sv @@
// Goal transfer: no result; busy computing the coefficients of each axis in turn.
// Tick transfer past the end or while idle: result is the end positions, sent via ST_PUSH.
// Tick transfer in motion: the result is computed after acceptance by the bit-serial divider
// and the shared serial multipliers, one bit a cycle, then sent via ST_PUSH.
// One item at a time; a held output stalls the next result in ST_PUSH, and with it input.
// Reset: idle, duration 5000, end position zero on every axis.
`include "cubic_trajectory_interpolator_defines.svh"
module cubic_trajectory_interpolator import ctip_pkg::*; #(
	parameter int AXES = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// start x.., speed x.., target x.., 32 bits each per axis
	input  logic [3*AXES*POS_W-1:0] s_tdata,
	// opcode
	input  logic [0:0]              s_tuser,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// setpoint x.., 32 bits each per axis
	output logic [AXES*POS_W-1:0]   m_tdata,
	// finished
	output logic [0:0]              m_tuser
);
	localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_GVT  = 9'b000000010,
		ST_DIV  = 9'b000000100,
		ST_S2   = 9'b000001000,
		ST_S3   = 9'b000010000,
		ST_VT   = 9'b000100000,
		ST_QM   = 9'b001000000,
		ST_CM   = 9'b010000000,
		ST_PUSH = 9'b100000000
	} state_t;

	state_t state_q;
	logic [TICK_W-1:0] dur_q, span_q, elapsed_q;
	logic moving_q;
	logic [AXW-1:0] ax_q, ax_nx;
	logic signed [POS_W-1:0]  orig_q [AXES];
	logic signed [POS_W-1:0]  speed_q [AXES];
	logic signed [POS_W-1:0]  end_q [AXES];
	logic signed [COEF_W-1:0] quad_q [AXES];
	logic signed [COEF_W-1:0] cubic_q [AXES];
	logic [POS_W-1:0] res_q [AXES];
	logic res_fin_q;
	logic [POS_W-1:0] s_q, s2_q, s3_q;
	logic signed [COEF_W-1:0] acc_q;
	logic m_tvalid_q;
	logic [AXES*POS_W-1:0] m_tdata_q;
	logic m_tuser_q;

	logic dv_go_q, im_go_q, fm_go_q;
	logic signed [POS_W-1:0] im_a_q;
	logic [TICK_W-1:0] im_b_q;
	logic signed [COEF_W-1:0] fm_a_q;
	logic [POS_W-1:0] fm_b_q;
	logic dv_done, im_done, fm_done;
	logic [POS_W-1:0] dv_q;
	logic signed [PROD_W-1:0] im_p;
	logic signed [COEF_W-1:0] fm_p;

	logic in_acc, cfg_wr, out_free;
	logic [TICK_W-1:0] el_n, dur_eff;
	logic signed [COEF_W-1:0] d_w, vt_w;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_DURATION);
	assign prdata   = (paddr[2] == REG_DURATION) ? {16'd0, dur_q} : 32'd0;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign ax_nx    = ax_q + AXW'(1);
	assign el_n     = elapsed_q + TICK_W'(1);
	assign dur_eff  = (dur_q == '0) ? TICK_W'(1) : dur_q;
	assign d_w      = COEF_W'(end_q[ax_q]) - COEF_W'(orig_q[ax_q]);
	assign vt_w     = COEF_W'(im_p);

	ctip_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_go_q), .num(elapsed_q), .den(span_q),
		.done(dv_done), .quo(dv_q)
	);
	ctip_imul u_imul (
		.clk(clk), .arst_n(arst_n), .start(im_go_q), .a(im_a_q), .b(im_b_q),
		.done(im_done), .p(im_p)
	);
	ctip_fmul u_fmul (
		.clk(clk), .arst_n(arst_n), .start(fm_go_q), .a(fm_a_q), .b(fm_b_q),
		.done(fm_done), .p(fm_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dur_q      <= DUR_RESET;
			span_q     <= TICK_W'(1);
			elapsed_q  <= '0;
			moving_q   <= 1'b0;
			ax_q       <= '0;
			m_tvalid_q <= 1'b0;
			dv_go_q    <= 1'b0;
			im_go_q    <= 1'b0;
			fm_go_q    <= 1'b0;
			for (int i = 0; i < AXES; i++) begin
				end_q[i] <= '0;
			end
		end else begin
			dv_go_q <= 1'b0;
			im_go_q <= 1'b0;
			fm_go_q <= 1'b0;
			if (cfg_wr) dur_q <= pwdata[TICK_W-1:0];
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser[0] == OP_GOAL) begin
							for (int i = 0; i < AXES; i++) begin
								end_q[i] <= s_tdata[(2*AXES+i)*POS_W +: POS_W];
							end
							span_q    <= dur_eff;
							elapsed_q <= '0;
							moving_q  <= 1'b1;
							ax_q      <= '0;
							im_a_q    <= s_tdata[AXES*POS_W +: POS_W];
							im_b_q    <= dur_eff;
							im_go_q   <= 1'b1;
							state_q   <= ST_GVT;
						end else begin
							if (moving_q) elapsed_q <= el_n;
							if (moving_q && (el_n < span_q) && (el_n != '0)) begin
								dv_go_q <= 1'b1;
								state_q <= ST_DIV;
							end else begin
								moving_q <= 1'b0;
								state_q  <= ST_PUSH;
							end
						end
					end
				end
				ST_GVT: begin
					if (im_done) begin
						if (ax_q == AXW'(AXES - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							ax_q    <= ax_nx;
							im_a_q  <= speed_q[ax_nx];
							im_go_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (dv_done) begin
						fm_a_q  <= COEF_W'(dv_q);
						fm_b_q  <= dv_q;
						fm_go_q <= 1'b1;
						state_q <= ST_S2;
					end
				end
				ST_S2: begin
					if (fm_done) begin
						fm_a_q  <= COEF_W'(fm_p[POS_W-1:0]);
						fm_b_q  <= s_q;
						fm_go_q <= 1'b1;
						state_q <= ST_S3;
					end
				end
				ST_S3: begin
					if (fm_done) begin
						ax_q    <= '0;
						im_a_q  <= speed_q[0];
						im_b_q  <= elapsed_q;
						im_go_q <= 1'b1;
						state_q <= ST_VT;
					end
				end
				ST_VT: begin
					if (im_done) begin
						fm_a_q  <= quad_q[ax_q];
						fm_b_q  <= s2_q;
						fm_go_q <= 1'b1;
						state_q <= ST_QM;
					end
				end
				ST_QM: begin
					if (fm_done) begin
						fm_a_q  <= cubic_q[ax_q];
						fm_b_q  <= s3_q;
						fm_go_q <= 1'b1;
						state_q <= ST_CM;
					end
				end
				ST_CM: begin
					if (fm_done) begin
						if (ax_q == AXW'(AXES - 1)) begin
							state_q <= ST_PUSH;
						end else begin
							ax_q    <= ax_nx;
							im_a_q  <= speed_q[ax_nx];
							im_go_q <= 1'b1;
							state_q <= ST_VT;
						end
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser[0] == OP_GOAL)) begin
			for (int i = 0; i < AXES; i++) begin
				orig_q[i]  <= s_tdata[i*POS_W +: POS_W];
				speed_q[i] <= s_tdata[(AXES+i)*POS_W +: POS_W];
			end
		end
		if (in_acc && (s_tuser[0] == OP_TICK)) begin
			for (int i = 0; i < AXES; i++) begin
				res_q[i] <= end_q[i];
			end
			res_fin_q <= 1'b1;
		end
		if ((state_q == ST_GVT) && im_done) begin
			quad_q[ax_q]  <= d_w + (d_w <<< 1) - (vt_w <<< 1);
			cubic_q[ax_q] <= vt_w - (d_w <<< 1);
		end
		if ((state_q == ST_DIV) && dv_done) s_q <= dv_q;
		if ((state_q == ST_S2) && fm_done) s2_q <= fm_p[POS_W-1:0];
		if ((state_q == ST_S3) && fm_done) s3_q <= fm_p[POS_W-1:0];
		if ((state_q == ST_VT) && im_done) acc_q <= COEF_W'(orig_q[ax_q]) + COEF_W'(im_p);
		if ((state_q == ST_QM) && fm_done) acc_q <= acc_q + fm_p;
		if ((state_q == ST_CM) && fm_done) begin
			res_q[ax_q] <= sat32(acc_q + fm_p);
			res_fin_q   <= 1'b0;
		end
		if ((state_q == ST_PUSH) && out_free) begin
			for (int i = 0; i < AXES; i++) begin
				m_tdata_q[i*POS_W +: POS_W] <= res_q[i];
			end
			m_tuser_q <= res_fin_q;
		end
	end

	`CTI_ASSERT_IMP(a_div_moving, state_q == ST_DIV, moving_q)
	`CTI_ASSERT_IMP(a_ax_range, state_q != ST_IDLE, ax_q <= AXW'(AXES - 1))
	`CTI_ASSERT_NXT(a_push_valid, (state_q == ST_PUSH) && out_free, m_tvalid_q)
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
	import ctip_pkg::*;

	localparam int AXES      = 3;
	localparam int IN_W      = 3 * AXES * POS_W;
	localparam int OUT_W     = AXES * POS_W;
	localparam int WDOG_MAX  = 20000;
	localparam int LONG_HOLD = 3000;
	localparam int DRAIN     = 500;

	typedef struct {
		logic [OUT_W-1:0] pos;
		logic             fin;
	} setpoint_t;

	class setpoint_scoreboard;
		setpoint_t      setpoints_due[$];
		int             errors;
		logic [15:0]    dur_reg;
		longint unsigned span;
		longint unsigned elapsed;
		bit             moving;
		longint         x0[AXES];
		longint         vel[AXES];
		longint         xe[AXES];
		longint         c2[AXES];
		longint         c3[AXES];

		function new();
			dur_reg = DUR_RESET;
			span    = 1;
			elapsed = 0;
			moving  = 0;
			errors  = 0;
			for (int i = 0; i < AXES; i++) begin
				x0[i] = 0; vel[i] = 0; xe[i] = 0; c2[i] = 0; c3[i] = 0;
			end
		endfunction

		function void set_duration(logic [15:0] v);
			dur_reg = v;
		endfunction

		function automatic logic [31:0] clip32(longint v);
			if (v > 64'sd2147483647) return 32'h7fff_ffff;
			if (v < -64'sd2147483648) return 32'h8000_0000;
			return v[31:0];
		endfunction

		// (a * b) >> 32, truncated toward zero
		function automatic longint frac_mul(longint a, longint unsigned b);
			bit neg;
			longint unsigned m, r;
			neg = a < 0;
			m = neg ? -a : a;
			r = (m >> 32) * b + (((m & 64'hffff_ffff) * b) >> 32);
			return neg ? -longint'(r) : longint'(r);
		endfunction

		function void note_input(logic op, logic [IN_W-1:0] d);
			setpoint_t e;
			longint unsigned s, s2, s3;
			longint delta, vt, x;
			if (op == OP_GOAL) begin
				span = (dur_reg == 0) ? 1 : dur_reg;
				for (int i = 0; i < AXES; i++) begin
					x0[i]  = $signed(d[i*POS_W +: POS_W]);
					vel[i] = $signed(d[(AXES+i)*POS_W +: POS_W]);
					xe[i]  = $signed(d[(2*AXES+i)*POS_W +: POS_W]);
					delta  = xe[i] - x0[i];
					vt     = vel[i] * longint'(span);
					c2[i]  = 3 * delta - 2 * vt;
					c3[i]  = vt - 2 * delta;
				end
				elapsed = 0;
				moving  = 1;
				return;
			end
			if (moving) begin
				elapsed = (elapsed + 1) & 16'hffff;
				if (elapsed >= span || elapsed == 0)
					moving = 0;
			end
			if (!moving) begin
				for (int i = 0; i < AXES; i++)
					e.pos[i*POS_W +: POS_W] = clip32(xe[i]);
				e.fin = 1;
			end else begin
				s  = (elapsed << 32) / span;
				s2 = (s * s) >> 32;
				s3 = (s2 * s) >> 32;
				for (int i = 0; i < AXES; i++) begin
					x = x0[i] + vel[i] * longint'(elapsed) + frac_mul(c2[i], s2)
						+ frac_mul(c3[i], s3);
					e.pos[i*POS_W +: POS_W] = clip32(x);
				end
				e.fin = 0;
			end
			setpoints_due.insert(setpoints_due.size(), e);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check(logic [OUT_W-1:0] pos, logic fin);
			setpoint_t e;
			if (setpoints_due.size() == 0) begin
				report("setpoint with none expected");
				return;
			end
			e = setpoints_due.pop_front();
			for (int i = 0; i < AXES; i++)
				if (pos[i*POS_W +: POS_W] !== e.pos[i*POS_W +: POS_W])
					report($sformatf("axis %0d got %h exp %h", i,
						pos[i*POS_W +: POS_W], e.pos[i*POS_W +: POS_W]));
			if (fin !== e.fin)
				report($sformatf("finished got %b exp %b", fin, e.fin));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             psel, penable, pwrite;
	logic [2:0]       paddr;
	logic [31:0]      pwdata, prdata;
	logic             pready;
	logic             s_tvalid, s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [0:0]       s_tuser;
	logic             m_tvalid, m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0]       m_tuser;

	setpoint_scoreboard sb;
	bit hold_req;
	bit rx_idle_ok;
	int idle_cycles;

	cubic_trajectory_interpolator #(.AXES(AXES)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		if (r < 98) return $urandom_range(5, 30);
		return $urandom_range(31, 200);
	endfunction

	// monitors
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready)
				sb.check(m_tdata, m_tuser[0]);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver
	initial begin
		int hold;
		hold = 0;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && hold == 0) begin
				hold_req = 0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 0;
			end else if (rx_idle_ok) begin
				m_tready <= ($urandom_range(0, 99) < 70);
			end else begin
				m_tready <= 1;
			end
		end
	end

	task automatic reg_write(logic [15:0] v);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {REG_DURATION, 2'b00};
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_duration(v);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send(logic op, logic [IN_W-1:0] d);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= op;
		s_tdata  <= d;
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 0;
		@(negedge clk);
		while (sb.setpoints_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return $urandom;
		if (r < 5) return (r & 1) ? 32'h7fff_ffff : 32'h8000_0000;
		return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
	endfunction

	function automatic logic [IN_W-1:0] rand_goal();
		logic [IN_W-1:0] d;
		for (int k = 0; k < 3 * AXES; k++)
			d[k*POS_W +: POS_W] = rand_val();
		return d;
	endfunction

	function automatic logic [IN_W-1:0] fill_goal(logic [31:0] p, logic [31:0] v,
			logic [31:0] t);
		logic [IN_W-1:0] d;
		for (int i = 0; i < AXES; i++) begin
			d[i*POS_W +: POS_W]          = p;
			d[(AXES+i)*POS_W +: POS_W]   = v;
			d[(2*AXES+i)*POS_W +: POS_W] = t;
		end
		return d;
	endfunction

	initial begin
		int sent, dur, nt;
		logic [15:0] durs[$];
		sb = new();
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = OP_TICK;
		hold_req = 0; rx_idle_ok = 0; idle_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// idle ticks after reset: zero end position, finished
		send(OP_TICK, rand_goal());
		send(OP_TICK, '1);
		settle();
		reg_write(16'd1);
		send(OP_GOAL, fill_goal(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
		send(OP_TICK, '0);
		send(OP_TICK, '0);
		settle();
		reg_write(16'd0);
		send(OP_GOAL, fill_goal(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
		send(OP_TICK, '0);
		settle();
		reg_write(16'd4);
		send(OP_GOAL, fill_goal(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
		send(OP_TICK, '0);
		send(OP_TICK, '0);
		// goal while moving restarts
		send(OP_GOAL, fill_goal(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		send(OP_TICK, '0);
		settle();
		// duration change mid-motion waits for next goal
		reg_write(16'd2);
		send(OP_TICK, '1);
		send(OP_TICK, '0);
		send(OP_TICK, '0);
		send(OP_TICK, '0);
		settle();
		reg_write(16'd65535);
		send(OP_GOAL, rand_goal());
		send(OP_TICK, '0);
		send(OP_TICK, '0);
		settle();
		reg_write(16'd5000);
		send(OP_GOAL, rand_goal());
		send(OP_TICK, '0);
		settle();

		rx_idle_ok = 1;
		durs = '{16'd1, 16'd3, 16'd7, 16'd0, 16'd12, 16'd65535, 16'd2, 16'd20, 16'd5,
			16'd5000};
		sent = 0;
		foreach (durs[p]) begin
			reg_write(durs[p]);
			dur = (durs[p] == 0) ? 1 : durs[p];
			if (p == 4)
				hold_req = 1;
			while (sent < (p + 1) * 200) begin
				if ($urandom_range(0, 9) < 8) begin
					send(OP_GOAL, rand_goal());
					sent++;
					nt = (dur > 24) ? $urandom_range(1, 20) : $urandom_range(1, dur + 3);
				end else begin
					nt = $urandom_range(1, 4);
				end
				for (int k = 0; k < nt; k++) begin
					send(OP_TICK, {$urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom});
					sent++;
				end
			end
			settle();
		end

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
